[hw/rtl/tmb_pkg.sv]
package tmb_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PERIOD_W  = 32;
    localparam int TIME_W    = 64;
    localparam int NSMS_W    = 20;
    localparam int PROD_W    = PERIOD_W + NSMS_W;
    localparam int ENTRY_W   = PERIOD_W + TIME_W;

    localparam logic [NSMS_W-1:0] NS_PER_MS = 20'd1000000;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_STOP    = 2'd1,
        OP_PROCESS = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic cap;
        logic stop_clr;
        logic mul_en;
        logic mul_proc;
        logic wr_start;
        logic wr_proc;
        logic rd;
        logic deact;
        logic fire;
        logic idx_inc;
        logic emit_status;
        logic emit_final;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic       in_pzero;
        logic       fired;
        logic       single;
        logic       pend_v;
        logic       out_free;
        logic       idx_last;
    } t_sts;

endpackage

[hw/rtl/tmb_ifs.sv]
interface tmb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  slot_id;
    logic [31:0] period_ms;
    logic        single_shot;
    logic [63:0] now_ns;

    modport source (output valid, operation, slot_id, period_ms, single_shot, now_ns,
                    input ready);
    modport sink (input valid, operation, slot_id, period_ms, single_shot, now_ns,
                  output ready);
endinterface

interface tmb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       status;
    logic       was_single_shot;
    logic       last;

    modport source (output valid, kind, fired_slot, status, was_single_shot, last,
                    input ready);
    modport sink (input valid, kind, fired_slot, status, was_single_shot, last,
                  output ready);
endinterface

[hw/rtl/periodic_oneshot_timer_bank_core.sv]
// Bank of NUM_SLOTS timer slots, all inactive after reset. Each input item is a start, a stop
// or a process, carrying the current time in ns; an unused code is taken and gives no result.
// Start and stop return one status result; a zero interval is refused with status 1.
// Process walks the slots in turn through the single read port of the slot memory that holds
// interval and deadline: a one-shot slot that fires is made inactive, a periodic slot that
// fires is rearmed (multiply, then rearm write), and the scan waits while results are not
// taken. Fired slots come out in ascending slot order with last on the final one; if none
// fire, a single nothing-fired result is given. A new item is taken while the final result
// still waits.
module periodic_oneshot_timer_bank_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmb_in_if.sink    i_in,
    tmb_out_if.source o_out
);
    import tmb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tmb_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/tmb_ram.sv]
module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tmb_ctrl.sv]
module tmb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tmb_pkg::t_sts i_sts,
    output tmb_pkg::t_cmd o_cmd
);
    import tmb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_WR    = 9'b000000100,
        S_STAT  = 9'b000001000,
        S_RD    = 9'b000010000,
        S_CMP   = 9'b000100000,
        S_PMUL  = 9'b001000000,
        S_PWR   = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    cmd.cap = 1'b1;
                    case (i_sts.in_op)
                        OP_START: begin
                            n_state = i_sts.in_pzero ? S_STAT : S_MUL;
                        end
                        OP_STOP: begin
                            cmd.stop_clr = 1'b1;
                            n_state      = S_STAT;
                        end
                        OP_PROCESS: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                n_state    = S_WR;
            end
            S_WR: begin
                cmd.wr_start = 1'b1;
                n_state      = S_STAT;
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_sts.fired) begin
                    cmd.idx_inc = !i_sts.idx_last;
                    n_state     = i_sts.idx_last ? S_FLUSH : S_RD;
                // a pending result must leave before the new one takes its place
                end else if (!i_sts.pend_v || i_sts.out_free) begin
                    cmd.fire = 1'b1;
                    if (i_sts.single) begin
                        cmd.deact   = 1'b1;
                        cmd.idx_inc = !i_sts.idx_last;
                        n_state     = i_sts.idx_last ? S_FLUSH : S_RD;
                    end else begin
                        n_state = S_PMUL;
                    end
                end
            end
            S_PMUL: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_proc = 1'b1;
                n_state      = S_PWR;
            end
            S_PWR: begin
                cmd.wr_proc = 1'b1;
                cmd.idx_inc = !i_sts.idx_last;
                n_state     = i_sts.idx_last ? S_FLUSH : S_RD;
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule

[hw/rtl/tmb_dpath.sv]
module tmb_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tmb_pkg::t_cmd i_cmd,
    output tmb_pkg::t_sts o_sts,
    tmb_in_if.sink        i_in,
    tmb_out_if.source     o_out
);
    import tmb_pkg::*;

    // captured item
    logic [1:0]          r_op;
    logic [3:0]          r_slot;
    logic [PERIOD_W-1:0] r_period;
    logic                r_oneshot;
    logic [TIME_W-1:0]   r_now;

    logic [SLOT_W-1:0]    r_idx;
    logic [PROD_W-1:0]    r_prod;
    logic [NUM_SLOTS-1:0] r_active;
    logic [NUM_SLOTS-1:0] r_single;

    // one fired slot held back until it is known whether it is the final one
    logic              r_pend_v;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              r_pend_ss;

    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [3:0] r_out_slot;
    logic       r_out_status;
    logic       r_out_ss;
    logic       r_out_last;

    logic [ENTRY_W-1:0]  rd_entry;
    logic [ENTRY_W-1:0]  wr_entry;
    logic [PERIOD_W-1:0] rd_period;
    logic [TIME_W-1:0]   rd_deadline;
    logic [PERIOD_W-1:0] mul_a;
    logic [SLOT_W-1:0]   in_sidx;
    logic [SLOT_W-1:0]   st_sidx;
    logic                in_range;
    logic                st_range;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic                out_free;
    logic                fired;

    assign in_sidx  = SLOT_W'(i_in.slot_id);
    assign st_sidx  = SLOT_W'(r_slot);
    assign in_range = (32'(i_in.slot_id) < NUM_SLOTS);
    assign st_range = (32'(r_slot) < NUM_SLOTS);

    assign rd_period   = rd_entry[ENTRY_W-1:TIME_W];
    assign rd_deadline = rd_entry[TIME_W-1:0];
    assign mul_a       = i_cmd.mul_proc ? rd_period : r_period;
    assign wr_entry    = {(i_cmd.wr_proc ? rd_period : r_period),
                          r_now + TIME_W'(r_prod)};
    assign ram_we      = i_cmd.wr_proc || (i_cmd.wr_start && st_range);
    assign ram_waddr   = i_cmd.wr_proc ? r_idx : st_sidx;

    tmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    assign fired    = r_active[r_idx] && (r_now >= rd_deadline);
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= i_in.operation;
            r_slot    <= i_in.slot_id;
            r_period  <= i_in.period_ms;
            r_oneshot <= i_in.single_shot;
            r_now     <= i_in.now_ns;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(NS_PER_MS);
        end
        if (i_cmd.fire) begin
            r_pend_slot <= r_idx;
            r_pend_ss   <= r_single[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_active <= '0;
            r_single <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.stop_clr && in_range) begin
                r_active[in_sidx] <= 1'b0;
            end
            if (i_cmd.wr_start && st_range) begin
                r_active[st_sidx] <= 1'b1;
                r_single[st_sidx] <= r_oneshot;
            end
            if (i_cmd.deact) begin
                r_active[r_idx] <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.emit_final) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_status || i_cmd.emit_final || (i_cmd.fire && r_pend_v)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_out_kind   <= KIND_STATUS;
            r_out_slot   <= r_slot;
            r_out_status <= (r_op == OP_START) && (r_period == '0);
            r_out_ss     <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.fire && r_pend_v) begin
            r_out_kind   <= KIND_FIRED;
            r_out_slot   <= 4'(r_pend_slot);
            r_out_status <= 1'b0;
            r_out_ss     <= r_pend_ss;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_kind   <= r_pend_v ? KIND_FIRED : KIND_NONE;
            r_out_slot   <= r_pend_v ? 4'(r_pend_slot) : 4'd0;
            r_out_status <= 1'b0;
            r_out_ss     <= r_pend_v && r_pend_ss;
            r_out_last   <= 1'b1;
        end
    end

    assign i_in.ready            = i_cmd.in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out_kind;
    assign o_out.fired_slot      = r_out_slot;
    assign o_out.status          = r_out_status;
    assign o_out.was_single_shot = r_out_ss;
    assign o_out.last            = r_out_last;

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.in_op    = i_in.operation;
    assign o_sts.in_pzero = (i_in.period_ms == '0);
    assign o_sts.fired    = fired;
    assign o_sts.single   = r_single[r_idx];
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.out_free = out_free;
    assign o_sts.idx_last = (r_idx == SLOT_W'(NUM_SLOTS - 1));

endmodule

[hw/rtl/tmb_checker.sv]
module tmb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_op,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [3:0] i_out_slot,
    input logic       i_out_status,
    input logic       i_out_ss,
    input logic       i_out_last
);
    import tmb_pkg::*;

    // result stays offered until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_kind) && $stable(i_out_slot)
            && $stable(i_out_status) && $stable(i_out_ss) && $stable(i_out_last))
        else $error("stalled result changed");

    // a scan is still running while a non-final fired result waits
    a_busy_mid_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken in the middle of a scan");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready
            && (i_in_op == OP_START || i_in_op == OP_STOP || i_in_op == OP_PROCESS)
            |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_STATUS || i_out_kind == KIND_NONE)
            |-> i_out_last && !i_out_ss)
        else $error("status or nothing-fired result not final");

endmodule

bind periodic_oneshot_timer_bank_core tmb_checker u_tmb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.operation),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.kind),
    .i_out_slot   (o_out.fired_slot),
    .i_out_status (o_out.status),
    .i_out_ss     (o_out.was_single_shot),
    .i_out_last   (o_out.last)
);

[tb/sv/tmb_timer_checker.sv]
`timescale 1ns / 100ps

module tmb_timer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tmb_in_if    i_in_mon,
    tmb_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_fires
);
    import tmb_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [3:0] slot;
        logic       status;
        logic       oneshot;
        logic       last;
    } t_timer_result;

    // shadow of the slot bank
    bit        armed       [NUM_SLOTS];
    bit        oneshot     [NUM_SLOTS];
    bit [31:0] slot_per_ms [NUM_SLOTS];
    bit [63:0] due_ns      [NUM_SLOTS];

    t_timer_result results_due_q[$];
    int err_count    = 0;
    int result_count = 0;
    int fired_total  = 0;

    assign o_errors  = err_count;
    assign o_results = result_count;
    assign o_fires   = fired_total;

    initial o_pending = 0;

    function automatic bit [63:0] deadline_after(bit [63:0] now, bit [31:0] ms);
        return now + 64'(ms) * 64'(NS_PER_MS);
    endfunction

    task automatic push_result(t_kind k, logic [3:0] s, logic st, logic os, logic l);
        t_timer_result r;
        r.kind    = k;
        r.slot    = s;
        r.status  = st;
        r.oneshot = os;
        r.last    = l;
        results_due_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic predict_timer_op(logic [1:0] op, logic [3:0] slot, logic [31:0] per,
                                    logic ss, logic [63:0] now);
        int n;
        n = 0;
        case (op)
            OP_START: begin
                if (per == 32'd0) begin
                    // refused, slot untouched
                    push_result(KIND_STATUS, slot, 1'b1, 1'b0, 1'b1);
                end else begin
                    armed[slot]       = 1'b1;
                    oneshot[slot]     = ss;
                    slot_per_ms[slot] = per;
                    due_ns[slot]      = deadline_after(now, per);
                    push_result(KIND_STATUS, slot, 1'b0, 1'b0, 1'b1);
                end
            end
            OP_STOP: begin
                armed[slot] = 1'b0;
                push_result(KIND_STATUS, slot, 1'b0, 1'b0, 1'b1);
            end
            OP_PROCESS: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (armed[i] && now >= due_ns[i]) begin
                        push_result(KIND_FIRED, 4'(i), 1'b0, oneshot[i], 1'b0);
                        n++;
                        if (oneshot[i]) begin
                            armed[i] = 1'b0;
                        end else begin
                            due_ns[i] = deadline_after(now, slot_per_ms[i]);
                        end
                    end
                end
                if (n == 0) begin
                    push_result(KIND_NONE, 4'd0, 1'b0, 1'b0, 1'b1);
                end else begin
                    results_due_q[results_due_q.size() - 1].last = 1'b1;
                end
            end
            default: ;  // unused code, no result
        endcase
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_timer_op(i_in_mon.operation, i_in_mon.slot_id, i_in_mon.period_ms,
                                 i_in_mon.single_shot, i_in_mon.now_ns);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                result_count++;
                if (i_out_mon.kind == KIND_FIRED) fired_total++;
                if (results_due_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding, kind", i_out_mon.kind, -1);
                end else begin
                    want = results_due_q.pop_front();
                    if (i_out_mon.kind !== want.kind)
                        report_mismatch("kind", i_out_mon.kind, want.kind);
                    if (i_out_mon.fired_slot !== want.slot)
                        report_mismatch("fired_slot", i_out_mon.fired_slot, want.slot);
                    if (i_out_mon.status !== want.status)
                        report_mismatch("status", i_out_mon.status, want.status);
                    if (i_out_mon.was_single_shot !== want.oneshot)
                        report_mismatch("was_single_shot", i_out_mon.was_single_shot,
                                        want.oneshot);
                    if (i_out_mon.last !== want.last)
                        report_mismatch("last", i_out_mon.last, want.last);
                end
            end
        end
        o_pending <= results_due_q.size();
    end

endmodule

[tb/sv/tb_periodic_oneshot_timer_bank_core.sv]
`timescale 1ns / 100ps

module tb_periodic_oneshot_timer_bank_core;
    import tmb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 4 * NUM_SLOTS + 16;

    logic i_clk;
    logic i_rst_n;

    tmb_in_if  in_ch ();
    tmb_out_if out_ch ();

    int        errors;
    int        pending;
    int        results;
    int        fires;
    int        stall_pct;
    int        hold_requests;
    int        holds_served;
    int        gap_pct;
    int        items_sent;
    logic [63:0] t_now;

    periodic_oneshot_timer_bank_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tmb_timer_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_ch),
        .i_out_mon (out_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results),
        .o_fires   (fires)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = holds_served + 1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= (i_rst_n && $urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [3:0] slot, logic [31:0] per, logic ss,
                             logic [63:0] now);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.slot_id     <= slot;
        in_ch.period_ms   <= per;
        in_ch.single_shot <= ss;
        in_ch.now_ns      <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_op();
        int          r;
        logic [31:0] per;
        logic [3:0]  slot;
        r    = $urandom_range(99);
        slot = 4'($urandom_range(NUM_SLOTS - 1));
        if (r < 40) begin
            case ($urandom_range(9))
                0:       per = 32'd0;
                1:       per = $urandom;
                2:       per = 32'hFFFF_FFFF;
                default: per = 32'($urandom_range(1, 12));
            endcase
            send_item(OP_START, slot, per, 1'($urandom_range(1)), t_now);
        end else if (r < 55) begin
            send_item(OP_STOP, slot, $urandom, 1'($urandom_range(1)), t_now);
        end else if (r < 94) begin
            t_now += 64'($urandom_range(0, 9_000_000));
            send_item(OP_PROCESS, slot, $urandom, 1'($urandom_range(1)), t_now);
        end else if (r < 97) begin
            // time jump anywhere in the 64-bit range
            send_item(OP_PROCESS, slot, $urandom, 1'($urandom_range(1)), {$urandom, $urandom});
        end else begin
            send_item(OP_UNUSED, slot, $urandom, 1'($urandom_range(1)), {$urandom, $urandom});
        end
    endtask

    // arm the whole bank with short intervals, then tick past them all
    task automatic fire_whole_bank();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            send_item(OP_START, 4'(s), 32'($urandom_range(1, 4)), 1'($urandom_range(1)), t_now);
        end
        t_now += 64'd5_000_000;
        send_item(OP_PROCESS, 4'd0, 32'd0, 1'b0, t_now);
        t_now += 64'd4_000_000;
        send_item(OP_PROCESS, 4'd0, 32'd0, 1'b0, t_now);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_START;
        in_ch.slot_id     <= '0;
        in_ch.period_ms   <= '0;
        in_ch.single_shot <= 1'b0;
        in_ch.now_ns      <= '0;
        stall_pct         <= 0;
        hold_requests     <= 0;
        gap_pct    = 0;
        items_sent = 0;
        t_now      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner cases
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, 64'd0);
        send_item(OP_START,   4'd0,  32'd1,         1'b1, 64'd0);
        send_item(OP_START,   4'd15, 32'hFFFF_FFFF, 1'b0, 64'd0);
        send_item(OP_START,   4'd3,  32'd0,         1'b1, 64'd0);
        send_item(OP_STOP,    4'd7,  32'd0,         1'b0, 64'd0);
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, 64'd999_999);
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, 64'd1_000_000);
        // deadline wraps past the top of the time range
        send_item(OP_START,   4'd5,  32'd2,         1'b0, ~64'd9);
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, ~64'd0);
        send_item(OP_START,   4'd5,  32'd7,         1'b1, 64'd0);
        send_item(OP_START,   4'd15, 32'd0,         1'b1, 64'd0);
        send_item(OP_UNUSED,  4'd15, 32'hFFFF_FFFF, 1'b1, ~64'd0);
        send_item(OP_STOP,    4'd15, 32'hFFFF_FFFF, 1'b1, ~64'd0);
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, 64'd7_000_000);
        send_item(OP_PROCESS, 4'd0,  32'd0,         1'b0, 64'd7_000_000);
        wait_all_results();
        t_now = 64'd7_000_000;

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 54; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 54; end
                default: begin gap_pct = 30; stall_pct <= 30; end
            endcase
            // long output hold-off while items keep coming
            if (mode == 0) hold_requests <= hold_requests + 1;
            for (int k = 0; k < 60; k++) begin
                if (k == 30) fire_whole_bank();
                send_random_op();
            end
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d items in, %0d results checked, %0d of them slot fires",
                 items_sent, results, fires);
        $display("corner cases, full-bank fires, four idle/stall mixes, a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
